>>> sv/fht_pkg.sv
// ----------------------------------------------------------------------------
// fht_pkg
// Shared types and codes of the fingerprint hash table.
// ----------------------------------------------------------------------------
package fht_pkg;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned FP_BYTES  = 16;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 11'd1024;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] fp_high;
    logic [63:0] fp_low;
    logic [31:0] block;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] found_block;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_FILL,
    BK_SCAN,
    BK_MOVE,
    BK_RESP
  } back_state_e;

endpackage

>>> sv/fht_if.sv
// ----------------------------------------------------------------------------
// fht_req_if / fht_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface fht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] fp_high;
  logic [63:0] fp_low;
  logic [31:0] block;

  modport source (output valid, func, fp_high, fp_low, block, input ready);
  modport sink   (input valid, func, fp_high, fp_low, block, output ready);
endinterface

interface fht_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] found_block;
  logic [1:0]  status;

  modport source (output valid, found, found_block, status, input ready);
  modport sink   (input valid, found, found_block, status, output ready);
endinterface

>>> sv/fht_ram.sv
// ----------------------------------------------------------------------------
// fht_ram
// Generic RAM, one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/fht_fifo.sv
// ----------------------------------------------------------------------------
// fht_fifo
// Two-entry queue between the hash front end and the table back end.
// ----------------------------------------------------------------------------
module fht_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/fht_hash.sv
// ----------------------------------------------------------------------------
// fht_hash
// Front end: accepts requests and computes the bucket index, one
// fingerprint byte at a time with a restoring modulo reduction.
// ----------------------------------------------------------------------------
module fht_hash #(
  parameter int unsigned BW = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [fht_pkg::CFG_W-1:0]  mod_i,
  fht_req_if.sink                    req_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output fht_pkg::req_t              push_item_o,
  output logic [BW-1:0]              push_bucket_o
);
  import fht_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [CFG_W-1:0] r_q, r_d;
  logic [CFG_W-1:0] part_q, part_d;
  logic [7:0]       xl_q, xl_d;
  req_t             item_q, item_d;
  logic [127:0]     fp;
  logic [7:0]       fp_byte;
  logic [15:0]      x;
  logic             accept;

  function automatic logic [CFG_W-1:0] reduce8(logic [CFG_W-1:0] rem_in,
                                               logic [7:0] bits,
                                               logic [CFG_W-1:0] m);
    logic [CFG_W-1:0] rem;
    logic [CFG_W:0]   t;
    rem = rem_in;
    for (int i = 7; i >= 0; i--) begin
      t = {rem, bits[i]};
      if (t >= {1'b0, m}) begin
        rem = CFG_W'(t - {1'b0, m});
      end else begin
        rem = t[CFG_W-1:0];
      end
    end
    return rem;
  endfunction

  assign req_i.ready   = en_i && !busy_q && (!done_q || push_ready_i);
  assign accept        = req_i.valid && req_i.ready;
  assign push_valid_o  = done_q;
  assign push_item_o   = item_q;
  assign push_bucket_o = BW'(r_q);

  assign fp      = {item_q.fp_high, item_q.fp_low};
  assign fp_byte = fp[8*(15 - int'(cnt_q[4:1])) +: 8];
  assign x       = 16'({r_q, 4'b0000}) + 16'(fp_byte);

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    part_d = part_q;
    xl_d   = xl_q;
    item_d = item_q;
    if (done_q && push_ready_i) begin
      done_d = 1'b0;
    end
    if (busy_q) begin
      cnt_d = cnt_q + 5'd1;
      if (!cnt_q[0]) begin
        part_d = reduce8('0, x[15:8], mod_i);
        xl_d   = x[7:0];
      end else begin
        r_d = reduce8(part_q, xl_q, mod_i);
        if (cnt_q == 5'd31) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
    if (accept) begin
      item_d.func    = req_i.func;
      item_d.fp_high = req_i.fp_high;
      item_d.fp_low  = req_i.fp_low;
      item_d.block   = req_i.block;
      busy_d         = 1'b1;
      cnt_d          = 5'd0;
      r_d            = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    part_q <= part_d;
    xl_q   <= xl_d;
    item_q <= item_d;
  end

endmodule

>>> sv/fht_back.sv
// ----------------------------------------------------------------------------
// fht_back
// Back end: bucket read-modify-write sequencer over the fill and entry RAMs.
// ----------------------------------------------------------------------------
module fht_back #(
  parameter int unsigned NUM_BUCKETS = 1024,
  parameter int unsigned WAYS        = 4,
  parameter int unsigned BW          = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          clearing_o,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  fht_pkg::req_t q_item_i,
  input  logic [BW-1:0] q_bucket_i,
  fht_rsp_if.source     rsp_o
);
  import fht_pkg::*;

  localparam int unsigned SLOTS = NUM_BUCKETS * WAYS;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FW    = $clog2(WAYS + 1);
  localparam int unsigned EW    = 160;

  back_state_e    state_q, state_d;
  logic [BW-1:0]  clr_q, clr_d;
  logic [1:0]     op_q, op_d;
  logic [63:0]    hi_q, hi_d;
  logic [63:0]    lo_q, lo_d;
  logic [31:0]    blk_q, blk_d;
  logic [BW-1:0]  bucket_q, bucket_d;
  logic [FW-1:0]  n_q, n_d;
  logic [FW-1:0]  w_q, w_d;
  rsp_t           res_q, res_d;
  logic           ov_q, ov_d;
  rsp_t           out_q, out_d;

  logic           fill_we, fill_re;
  logic [BW-1:0]  fill_waddr, fill_raddr;
  logic [FW-1:0]  fill_wdata, fill_rdata;
  logic           ent_we, ent_re;
  logic [AW-1:0]  ent_waddr, ent_raddr;
  logic [EW-1:0]  ent_wdata, ent_rdata;
  logic [AW-1:0]  base;
  logic           match;
  rsp_t           miss;

  fht_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_fill (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .re_i    (fill_re),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  fht_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entry (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  function automatic logic [AW-1:0] slot_addr(logic [AW-1:0] b, logic [FW:0] s);
    return b + AW'(s);
  endfunction

  assign base        = AW'(bucket_q) * AW'(WAYS);
  assign match       = (ent_rdata[159:96] == hi_q) && (ent_rdata[95:32] == lo_q);
  assign miss        = '{found: 1'b0, found_block: 32'd0, status: STATUS_NOT_FOUND};
  assign clearing_o  = (state_q == BK_CLEAR);
  assign rsp_o.valid       = ov_q;
  assign rsp_o.found       = out_q.found;
  assign rsp_o.found_block = out_q.found_block;
  assign rsp_o.status      = out_q.status;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    op_d       = op_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    blk_d      = blk_q;
    bucket_d   = bucket_q;
    n_d        = n_q;
    w_d        = w_q;
    res_d      = res_q;
    ov_d       = ov_q;
    out_d      = out_q;
    fill_we    = 1'b0;
    fill_waddr = bucket_q;
    fill_wdata = '0;
    fill_re    = 1'b0;
    fill_raddr = q_bucket_i;
    ent_we     = 1'b0;
    ent_waddr  = base;
    ent_wdata  = {hi_q, lo_q, blk_q};
    ent_re     = 1'b0;
    ent_raddr  = base;
    q_pop_o    = 1'b0;

    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      BK_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        if (clr_q == BW'(NUM_BUCKETS - 1)) begin
          state_d = BK_IDLE;
        end else begin
          clr_d = clr_q + BW'(1);
        end
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          fill_re  = 1'b1;
          op_d     = q_item_i.func;
          hi_d     = q_item_i.fp_high;
          lo_d     = q_item_i.fp_low;
          blk_d    = q_item_i.block;
          bucket_d = q_bucket_i;
          state_d  = BK_FILL;
        end
      end
      BK_FILL: begin
        n_d     = fill_rdata;
        res_d   = miss;
        state_d = BK_RESP;
        case (op_q) inside
          FUNC_INSERT: begin
            if (32'(fill_rdata) >= WAYS) begin
              res_d.status = STATUS_FULL;
            end else begin
              ent_we       = 1'b1;
              ent_waddr    = slot_addr(base, {1'b0, fill_rdata});
              fill_we      = 1'b1;
              fill_wdata   = fill_rdata + FW'(1);
              res_d.status = STATUS_DONE;
            end
          end
          FUNC_LOOKUP, FUNC_REMOVE: begin
            if (fill_rdata != '0) begin
              w_d       = fill_rdata - FW'(1);
              ent_re    = 1'b1;
              ent_raddr = slot_addr(base, {1'b0, fill_rdata - FW'(1)});
              state_d   = BK_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      BK_SCAN: begin
        if (match) begin
          res_d.found  = 1'b1;
          res_d.status = STATUS_DONE;
          if (op_q == FUNC_LOOKUP) begin
            res_d.found_block = ent_rdata[31:0];
            state_d           = BK_RESP;
          end else begin
            res_d.found_block = 32'd0;
            fill_we           = 1'b1;
            fill_wdata        = n_q - FW'(1);
            if (({1'b0, w_q} + (FW+1)'(1)) < {1'b0, n_q}) begin
              ent_re    = 1'b1;
              ent_raddr = slot_addr(base, {1'b0, w_q} + (FW+1)'(1));
              state_d   = BK_MOVE;
            end else begin
              state_d = BK_RESP;
            end
          end
        end else if (w_q == '0) begin
          res_d   = miss;
          state_d = BK_RESP;
        end else begin
          w_d       = w_q - FW'(1);
          ent_re    = 1'b1;
          ent_raddr = slot_addr(base, {1'b0, w_q} - (FW+1)'(1));
        end
      end
      BK_MOVE: begin
        ent_we    = 1'b1;
        ent_waddr = slot_addr(base, {1'b0, w_q});
        ent_wdata = ent_rdata;
        if (({1'b0, w_q} + (FW+1)'(2)) < {1'b0, n_q}) begin
          w_d       = w_q + FW'(1);
          ent_re    = 1'b1;
          ent_raddr = slot_addr(base, {1'b0, w_q} + (FW+1)'(2));
        end else begin
          state_d = BK_RESP;
        end
      end
      BK_RESP: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          out_d   = res_q;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    blk_q    <= blk_d;
    bucket_q <= bucket_d;
    n_q      <= n_d;
    w_q      <= w_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

endmodule

>>> sv/fingerprint_hash_table.sv
// ----------------------------------------------------------------------------
// fingerprint_hash_table
// Deduplication index from 128-bit fingerprints to block numbers, bucketed
// with WAYS entries per bucket.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_i    in   valid/ready   func, fp_high, fp_low, block
//  rsp_o    out  valid/ready   found, found_block, status
//  cfg      in   cfg_we_i      cfg_wdata_i (bucket_count)
//
//  Hash front end: works through the fingerprint one byte at a time, then
//  hands the item off; it takes no new request until that hand-off is made.
//  Back end: reads the fill count, then scans or moves entries in the bucket
//  RAMs; it overlaps the hashing of the next item through a 2-entry queue.
//  After reset a clearing pass over all NUM_BUCKETS buckets zeroes the fill
//  counts; req_i.ready stays low meanwhile. A stalled rsp_o holds one result
//  while the front end keeps hashing.
// ----------------------------------------------------------------------------
module fingerprint_hash_table #(
  parameter int unsigned NUM_BUCKETS = 1024,
  parameter int unsigned WAYS        = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [fht_pkg::CFG_W-1:0] cfg_wdata_i,
  fht_req_if.sink                   req_i,
  fht_rsp_if.source                 rsp_o
);
  import fht_pkg::*;

  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned QW = $bits(req_t) + BW;

  logic [CFG_W-1:0] bucket_count_q;
  logic [CFG_W-1:0] mod;
  logic             clearing;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  req_t             push_item, pop_item;
  logic [BW-1:0]    push_bucket, pop_bucket;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BUCKET_COUNT_RST;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (bucket_count_q == '0) begin
      mod = CFG_W'(1);
    end else if (32'(bucket_count_q) > NUM_BUCKETS) begin
      mod = CFG_W'(NUM_BUCKETS);
    end else begin
      mod = bucket_count_q;
    end
  end

  fht_hash #(.BW(BW)) u_hash (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (!clearing),
    .mod_i         (mod),
    .req_i         (req_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item),
    .push_bucket_o (push_bucket)
  );

  fht_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_item, push_bucket}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   ({pop_item, pop_bucket})
  );

  fht_back #(.NUM_BUCKETS(NUM_BUCKETS), .WAYS(WAYS), .BW(BW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clearing_o (clearing),
    .q_valid_i  (pop_valid),
    .q_pop_o    (pop_ready),
    .q_item_i   (pop_item),
    .q_bucket_i (pop_bucket),
    .rsp_o      (rsp_o)
  );

endmodule

>>> sv/fht_checker.sv
// ----------------------------------------------------------------------------
// fht_checker
// Port-level checks of the fingerprint hash table result channel.
// ----------------------------------------------------------------------------
module fht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        rsp_found_i,
  input logic [31:0] rsp_found_block_i,
  input logic [1:0]  rsp_status_i
);
  import fht_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == STATUS_DONE || rsp_status_i == STATUS_NOT_FOUND ||
                     rsp_status_i == STATUS_FULL))
    else $error("bad status code");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_found_i |-> rsp_status_i == STATUS_DONE)
    else $error("found without done status");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != STATUS_DONE |-> !rsp_found_i && rsp_found_block_i == 32'd0)
    else $error("failed result carries data");

endmodule

bind fingerprint_hash_table fht_checker u_fht_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_found_i       (rsp_o.found),
  .rsp_found_block_i (rsp_o.found_block),
  .rsp_status_i      (rsp_o.status)
);
